[rtl/core/slnp_pkg.sv]
// Shared types and constants for the sorted list in a node pool.
// No dependencies. Used by slnp_cell and sorted_list_in_node_pool.
package slnp_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam logic [31:0] MAX_RESULTS = 32'd16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [VALUE_W-1:0] ins_value;
  } cell_ctl_t;

endpackage

[rtl/core/slnp_cell.sv]
// One cell of the sorted chain: holds one list entry (value and pool slot).
// Depends on slnp_pkg.
module slnp_cell #(
  parameter int SLOT_W = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slnp_pkg::cell_ctl_t                 ctl,
  input  logic [SLOT_W-1:0]                   ins_slot,
  input  logic                                left_valid,
  input  logic signed [slnp_pkg::VALUE_W-1:0] left_value,
  input  logic [SLOT_W-1:0]                   left_slot,
  input  logic                                left_lt,
  input  logic                                right_valid,
  input  logic signed [slnp_pkg::VALUE_W-1:0] right_value,
  input  logic [SLOT_W-1:0]                   right_slot,
  input  logic signed [slnp_pkg::VALUE_W-1:0] head_value,
  input  logic [SLOT_W-1:0]                   head_slot,
  output logic                                valid,
  output logic signed [slnp_pkg::VALUE_W-1:0] value,
  output logic [SLOT_W-1:0]                   slot,
  output logic                                lt
);

  logic                                valid_r, valid_nxt;
  logic signed [slnp_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [SLOT_W-1:0]                   slot_r, slot_nxt;

  // Entries are kept ascending, so the cells that compare less form a prefix.
  assign lt = valid_r && (value_r < ctl.ins_value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    slot_nxt  = slot_r;
    unique case (ctl.op)
      slnp_pkg::CELL_INSERT: begin
        if (!lt) begin
          if (left_lt) begin
            valid_nxt = 1'b1;
            value_nxt = ctl.ins_value;
            slot_nxt  = ins_slot;
          end else begin
            valid_nxt = left_valid;
            value_nxt = left_value;
            slot_nxt  = left_slot;
          end
        end
      end
      slnp_pkg::CELL_ROTATE: begin
        // The last occupied cell takes the head entry; the rest shift down.
        if (right_valid) begin
          value_nxt = right_value;
          slot_nxt  = right_slot;
        end else if (valid_r) begin
          value_nxt = head_value;
          slot_nxt  = head_slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    slot_r  <= slot_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign slot  = slot_r;

endmodule

[rtl/core/sorted_list_in_node_pool.sv]
// Top level of the sorted list in a node pool: control and the chain of cells.
// Depends on slnp_pkg and slnp_cell.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; in_cmd selects insert or dump, in_value is the signed value to insert.
// Results appear on the out_ ports for exactly one cycle with out_strobe high.
// Insert: one result in the cycle after the request (status inserted with the
// pool slot taken, or pool full). Busy stays low, so a new request may follow
// in the very next cycle. Slots are handed out from the highest one downward
// and are never given back.
// Dump: the entries leave in ascending order, one per cycle, once the state
// has moved to dump and the head entry has passed the output registers; equal
// values come out newest first, since an insert goes ahead of every entry that
// is not less than it. Busy stays high while the chain rotates once over all
// stored entries (at most POOL_SLOTS). Only the first sixteen entries are
// reported; the final result carries out_last. An empty list gives a single
// result with the empty status in the cycle after the request.
// Reset (synchronous, rst_n low) empties the list and returns every slot to the
// pool. The receiver cannot stall: results must be taken as they appear.
// Each cell compares its entry with the broadcast insert value in parallel, so
// an insert updates every cell at once, whatever the list length.
module sorted_list_in_node_pool #(
  parameter int POOL_SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic signed [slnp_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_strobe,
  output logic [slnp_pkg::STATUS_W-1:0]        out_status,
  output logic signed [slnp_pkg::VALUE_W-1:0]  out_entry_value,
  output logic [slnp_pkg::SLOT_OUT_W-1:0]      out_slot,
  output logic                                 out_last
);

  localparam int SLOT_W  = $clog2(POOL_SLOTS);
  localparam int COUNT_W = $clog2(POOL_SLOTS + 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(POOL_SLOTS);
  localparam logic [COUNT_W-1:0] COUNT_TOP  = COUNT_W'(POOL_SLOTS - 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                               state_r;
  logic [COUNT_W-1:0]                   count_r;
  logic [COUNT_W-1:0]                   idx_r;
  logic                                 out_strobe_r;
  logic [slnp_pkg::STATUS_W-1:0]        out_status_r;
  logic signed [slnp_pkg::VALUE_W-1:0]  out_value_r;
  logic [SLOT_W-1:0]                    out_slot_r;
  logic                                 out_last_r;

  slnp_pkg::cell_ctl_t                  ctl;
  logic                                 accept;
  logic                                 full;
  logic [SLOT_W-1:0]                    free_slot;
  logic                                 dump_emit;
  logic                                 dump_last;
  logic                                 dump_done;
  logic [SLOT_W+slnp_pkg::SLOT_OUT_W-1:0] slot_wide;

  logic                                 c_valid [POOL_SLOTS];
  logic signed [slnp_pkg::VALUE_W-1:0]  c_value [POOL_SLOTS];
  logic [SLOT_W-1:0]                    c_slot  [POOL_SLOTS];
  logic                                 c_lt    [POOL_SLOTS];

  assign busy   = (state_r == S_DUMP);
  assign accept = start && !busy;
  assign full   = (count_r == COUNT_FULL);

  // With no node ever freed, the head of the free chain is the slot just
  // below the last one handed out.
  assign free_slot = SLOT_W'(COUNT_TOP - count_r);

  // Dump bookkeeping: idx_r counts rotation steps; output stops after the
  // sixteenth entry but the rotation runs over all entries to restore order.
  assign dump_emit = (32'(idx_r) < slnp_pkg::MAX_RESULTS);
  assign dump_done = (idx_r == count_r - COUNT_W'(1));
  assign dump_last = dump_done || (32'(idx_r) == slnp_pkg::MAX_RESULTS - 32'd1);

  always_comb begin
    ctl.op        = slnp_pkg::CELL_HOLD;
    ctl.ins_value = in_value;
    if (state_r == S_DUMP) begin
      ctl.op = slnp_pkg::CELL_ROTATE;
    end else if (accept && in_cmd == slnp_pkg::CMD_INSERT && !full) begin
      ctl.op = slnp_pkg::CELL_INSERT;
    end
  end

  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    logic                                l_valid;
    logic signed [slnp_pkg::VALUE_W-1:0] l_value;
    logic [SLOT_W-1:0]                   l_slot;
    logic                                l_lt;
    logic                                r_valid;
    logic signed [slnp_pkg::VALUE_W-1:0] r_value;
    logic [SLOT_W-1:0]                   r_slot;

    if (i == 0) begin : g_first
      // The head cell sees a virtual left neighbor that is always less.
      assign l_valid = 1'b0;
      assign l_value = c_value[0];
      assign l_slot  = c_slot[0];
      assign l_lt    = 1'b1;
    end else begin : g_mid_l
      assign l_valid = c_valid[i-1];
      assign l_value = c_value[i-1];
      assign l_slot  = c_slot[i-1];
      assign l_lt    = c_lt[i-1];
    end

    if (i == POOL_SLOTS - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = c_value[0];
      assign r_slot  = c_slot[0];
    end else begin : g_mid_r
      assign r_valid = c_valid[i+1];
      assign r_value = c_value[i+1];
      assign r_slot  = c_slot[i+1];
    end

    slnp_cell #(
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .ins_slot    (free_slot),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .left_slot   (l_slot),
      .left_lt     (l_lt),
      .right_valid (r_valid),
      .right_value (r_value),
      .right_slot  (r_slot),
      .head_value  (c_value[0]),
      .head_slot   (c_slot[0]),
      .valid       (c_valid[i]),
      .value       (c_value[i]),
      .slot        (c_slot[i]),
      .lt          (c_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_strobe_r <= 1'b1;
            out_last_r   <= 1'b1;
            if (in_cmd == slnp_pkg::CMD_INSERT) begin
              out_value_r <= in_value;
              if (full) begin
                out_status_r <= slnp_pkg::ST_FULL;
                out_slot_r   <= '0;
              end else begin
                out_status_r <= slnp_pkg::ST_INSERTED;
                out_slot_r   <= free_slot;
                count_r      <= count_r + COUNT_W'(1);
              end
            end else if (count_r == '0) begin
              out_status_r <= slnp_pkg::ST_EMPTY;
              out_value_r  <= '0;
              out_slot_r   <= '0;
            end else begin
              // No result yet: entries leave from the dump state through the output registers.
              out_strobe_r <= 1'b0;
              idx_r        <= '0;
              state_r      <= S_DUMP;
            end
          end
        end
        S_DUMP: begin
          out_strobe_r <= dump_emit;
          out_status_r <= slnp_pkg::ST_ENTRY;
          out_value_r  <= c_value[0];
          out_slot_r   <= c_slot[0];
          out_last_r   <= dump_last;
          idx_r        <= idx_r + COUNT_W'(1);
          if (dump_done) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_wide       = {{slnp_pkg::SLOT_OUT_W{1'b0}}, out_slot_r};
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_slot        = slot_wide[slnp_pkg::SLOT_OUT_W-1:0];
  assign out_last        = out_last_r;

endmodule
